/* design/dsfr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_pkg - shared definitions for the DLE stuffed frame receiver
// Field widths, event codes, register indexes and the command item that
// travels from the front end to the delivery engine.
// ---------------------------------------------------------------------------
package dsfr_pkg;

   localparam int DATA_W          = 8;
   localparam int EVENT_W         = 2;
   localparam int LEN_W           = 7;
   localparam int CSR_IDX_W       = 2;
   localparam int FRAME_DEPTH_DEF = 64;
   localparam int CMDQ_DEPTH      = 2;

   localparam logic [DATA_W-1:0] LEAD_RST  = 8'd2;
   localparam logic [DATA_W-1:0] TRAIL_RST = 8'd3;
   localparam logic [DATA_W-1:0] ACK_RST   = 8'd6;
   localparam logic [DATA_W-1:0] ESC_RST   = 8'd16;

   typedef enum logic [EVENT_W-1:0] {
      EV_DATA  = 2'd0,
      EV_EMPTY = 2'd1,
      EV_ACK   = 2'd2
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAD  = 2'd0,
      CSR_TRAIL = 2'd1,
      CSR_ACK   = 2'd2,
      CSR_ESC   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_ACK   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [LEN_W-1:0]  len;
      logic              ovf;
   } cmd_type;

endpackage

/* design/dsfr_channels.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr channels - valid/ready interfaces for received bytes and results
// One interface per channel, each with a source and a sink modport.
// ---------------------------------------------------------------------------
interface dsfr_req_if;
   import dsfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dsfr_rsp_if;
   import dsfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;
   logic [DATA_W-1:0]  data_byte;
   logic [LEN_W-1:0]   frame_length;
   logic               overflow;
   logic               last;

   modport source (output valid, output event_res, output data_byte,
                   output frame_length, output overflow, output last, input ready);
   modport sink   (input valid, input event_res, input data_byte,
                   input frame_length, input overflow, input last, output ready);
endinterface

/* design/dsfr_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dsfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dsfr_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_front - byte classifier and frame store writer
// Holds the flag registers, the escape state, fill count and overflow flag.
// Stores data bytes and posts deliver / ack commands to the queue.
// ---------------------------------------------------------------------------
module dsfr_front #(
   parameter int FRAME_DEPTH = dsfr_pkg::FRAME_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dsfr_req_if.sink                       req,
   input  logic                           csr_we,
   input  logic [dsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsfr_pkg::DATA_W-1:0]    csr_wdata,
   input  logic                           q_full,
   input  logic                           deliver_busy,
   output logic                           push,
   output dsfr_pkg::cmd_type              push_cmd,
   output logic                           wr_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
   output logic [dsfr_pkg::DATA_W-1:0]    wr_data
);
   import dsfr_pkg::*;

   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   logic [DATA_W-1:0] lead_ff,  lead_in;
   logic [DATA_W-1:0] trail_ff, trail_in;
   logic [DATA_W-1:0] ack_ff,   ack_in;
   logic [DATA_W-1:0] esc_ff,   esc_in;
   logic [CNT_W-1:0]  fill_ff,  fill_in;
   logic              pend_ff,  pend_in;
   logic              ovf_ff,   ovf_in;

   logic is_lead, is_trail, is_ack, is_esc, is_store;
   logic room, need_q, need_wr, accept;

   // priority: leading, trailing, ack, escape; an escaped byte is always data
   always_comb begin
      is_lead  = !pend_ff && (req.rx_byte == lead_ff);
      is_trail = !pend_ff && !is_lead && (req.rx_byte == trail_ff);
      is_ack   = !pend_ff && !is_lead && !is_trail && (req.rx_byte == ack_ff);
      is_esc   = !pend_ff && !is_lead && !is_trail && !is_ack && (req.rx_byte == esc_ff);
      is_store = !is_lead && !is_trail && !is_ack && !is_esc;
   end

   assign room    = (fill_ff != CNT_W'(FRAME_DEPTH));
   assign need_q  = is_trail || is_ack;
   assign need_wr = is_store && room;

   // store writes wait until no delivery is queued or running
   assign req.ready = !(need_q && q_full) && !(need_wr && deliver_busy);
   assign accept    = req.valid && req.ready;

   assign push          = accept && need_q;
   assign push_cmd.kind = is_ack ? CMD_ACK : CMD_FRAME;
   assign push_cmd.len  = LEN_W'(fill_ff);
   assign push_cmd.ovf  = ovf_ff;

   assign wr_en   = accept && need_wr;
   assign wr_addr = fill_ff[ADDR_W-1:0];
   assign wr_data = req.rx_byte;

   always_comb begin
      lead_in  = lead_ff;
      trail_in = trail_ff;
      ack_in   = ack_ff;
      esc_in   = esc_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEAD:  lead_in  = csr_wdata;
            CSR_TRAIL: trail_in = csr_wdata;
            CSR_ACK:   ack_in   = csr_wdata;
            CSR_ESC:   esc_in   = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      fill_in = fill_ff;
      pend_in = pend_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         pend_in = is_esc;
         if (is_lead) begin
            fill_in = '0;
            ovf_in  = 1'b0;
         end else if (is_store) begin
            if (room) begin
               fill_in = fill_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= LEAD_RST;
         trail_ff <= TRAIL_RST;
         ack_ff   <= ACK_RST;
         esc_ff   <= ESC_RST;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         lead_ff  <= lead_in;
         trail_ff <= trail_in;
         ack_ff   <= ack_in;
         esc_ff   <= esc_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         ovf_ff   <= ovf_in;
      end
   end

   // fill count never passes the store depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FRAME_DEPTH))
      else $error("fill count beyond frame depth");

endmodule

/* design/dsfr_cmd_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_cmd_fifo - short command queue between front end and delivery engine
// ---------------------------------------------------------------------------
module dsfr_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dsfr_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output dsfr_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import dsfr_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          mem_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign full    = (cnt_ff == CNT_W'(CMDQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_cmd = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ptr_next(wptr_ff) : wptr_ff;
      rptr_in = pop  ? ptr_next(rptr_ff) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command popped from empty queue");

endmodule

/* design/dsfr_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_back - delivery engine
// Pops commands, walks the frame store for a deliver and drives the result
// channel from an output register.
// ---------------------------------------------------------------------------
module dsfr_back #(
   parameter int FRAME_DEPTH = dsfr_pkg::FRAME_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  dsfr_pkg::cmd_type              q_cmd,
   output logic                           pop,
   output logic                           busy,
   output logic                           rd_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
   input  logic [dsfr_pkg::DATA_W-1:0]    rd_data,
   dsfr_rsp_if.source                     rsp
);
   import dsfr_pkg::*;

   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff,   idx_in;
   logic [CNT_W-1:0]  len_ff,   len_in;
   logic              fovf_ff,  fovf_in;
   logic              rpend_ff, rpend_in;
   logic              rlast_ff, rlast_in;

   logic              ovld_ff,  ovld_in;
   event_type         oev_ff,   oev_in;
   logic [DATA_W-1:0] odata_ff, odata_in;
   logic [LEN_W-1:0]  olen_ff,  olen_in;
   logic              oovf_ff,  oovf_in;
   logic              olast_ff, olast_in;

   logic out_free, load, issue;

   assign out_free = !ovld_ff || rsp.ready;
   assign busy     = (state_ff != ST_IDLE);
   assign pop      = (state_ff == ST_IDLE) && !q_empty && out_free;
   assign issue    = (state_ff == ST_WALK) && !rpend_ff && out_free && (idx_ff != len_ff);
   assign rd_en    = issue;
   assign rd_addr  = idx_ff[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      fovf_in  = fovf_ff;
      rpend_in = issue;
      rlast_in = rlast_ff;
      load     = 1'b0;
      oev_in   = oev_ff;
      odata_in = odata_ff;
      olen_in  = olen_ff;
      oovf_in  = oovf_ff;
      olast_in = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (q_cmd.kind == CMD_ACK) begin
                  load     = 1'b1;
                  oev_in   = EV_ACK;
                  odata_in = '0;
                  olen_in  = '0;
                  oovf_in  = 1'b0;
                  olast_in = 1'b1;
               end else if (q_cmd.len == '0) begin
                  load     = 1'b1;
                  oev_in   = EV_EMPTY;
                  odata_in = '0;
                  olen_in  = '0;
                  oovf_in  = q_cmd.ovf;
                  olast_in = 1'b1;
               end else begin
                  idx_in   = '0;
                  len_in   = q_cmd.len[CNT_W-1:0];
                  fovf_in  = q_cmd.ovf;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (issue) begin
               idx_in   = idx_ff + CNT_W'(1);
               rlast_in = ((idx_ff + CNT_W'(1)) == len_ff);
            end
            // read data lands in the cycle after issue; the output slot is free then
            if (rpend_ff) begin
               load     = 1'b1;
               oev_in   = EV_DATA;
               odata_in = rd_data;
               olen_in  = LEN_W'(len_ff);
               oovf_in  = fovf_ff;
               olast_in = rlast_ff;
               if (rlast_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         ovld_in = 1'b1;
      end else if (rsp.ready) begin
         ovld_in = 1'b0;
      end else begin
         ovld_in = ovld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rpend_ff <= 1'b0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rpend_ff <= rpend_in;
         ovld_ff  <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      fovf_ff  <= fovf_in;
      rlast_ff <= rlast_in;
      oev_ff   <= oev_in;
      odata_ff <= odata_in;
      olen_ff  <= olen_in;
      oovf_ff  <= oovf_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid        = ovld_ff;
   assign rsp.event_res    = oev_ff;
   assign rsp.data_byte    = odata_ff;
   assign rsp.frame_length = olen_ff;
   assign rsp.overflow     = oovf_ff;
   assign rsp.last         = olast_ff;

   // a read is only issued into an empty output slot
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      rpend_ff |-> !ovld_ff)
      else $error("store read lands on an occupied output register");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= len_ff))
      else $error("walk index passed frame length");

endmodule

/* design/dle_stuffed_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dle_stuffed_frame_receiver_top - DLE byte stuffing deframer
// Receives serial bytes, strips escapes, stores frame bytes and replays the
// stored frame as a run of result items on a trailing flag.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      rx_byte
//   rsp_ch    out   valid / ready      event_res, data_byte, frame_length,
//                                      overflow, last
//   csr_*     in    csr_we (no wait)   csr_index, csr_wdata
//
// Flow: a trailing flag queues a delivery; the engine walks the frame store
// through its one read port and issues the next read only once the data of
// the last one is in the output register. Ack and empty-frame events go
// straight from the queued command into the output register.
// Stalls: bytes that go into the store are held off while a delivery is
// queued or running, since the walk reads the same store; flags and acks
// keep flowing until the two-entry command queue fills.
// Reset: synchronous; clears the counters, flags, queue and output valid and
// loads the default flag values. The store needs no clearing pass, only
// entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module dle_stuffed_frame_receiver_top #(
   parameter int FRAME_DEPTH = dsfr_pkg::FRAME_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dsfr_req_if.sink                       req_ch,
   dsfr_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [dsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsfr_pkg::DATA_W-1:0]    csr_wdata
);
   import dsfr_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   logic              push, q_full, q_empty, pop, busy, deliver_busy;
   cmd_type           push_cmd, pop_cmd;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   // anything queued or in flight may read the store
   assign deliver_busy = !q_empty || busy;

   dsfr_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .deliver_busy (deliver_busy),
      .push         (push),
      .push_cmd     (push_cmd),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   dsfr_cmd_fifo u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   dsfr_ram #(.WIDTH(DATA_W), .DEPTH(FRAME_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dsfr_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .pop     (pop),
      .busy    (busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp_ch)
   );

   // the store is never written while a delivery could be reading it
   a_store_guard: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !deliver_busy)
      else $error("frame store written during delivery");

endmodule

/* test/tb_dle_stuffed_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dle_stuffed_frame_receiver_top - self-checking bench for the deframer
// Feeds received bytes through the request channel and tracks escapes,
// flags and the frame store in a scoreboard, which predicts every result
// item. Each result is checked field by field in arrival order. Runs a short
// directed sequence and then random framed traffic under several flag
// settings, with random idling on both sides and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_dle_stuffed_frame_receiver_top;
   import dsfr_pkg::*;

   localparam int          STORE_DEPTH = FRAME_DEPTH_DEF;
   localparam int unsigned HOLD_CYCLES = 1500; // long output hold-off
   localparam int unsigned FILL_BYTES  = 68;   // a few past the store depth

   // one result item as seen on rsp_ch
   typedef struct {
      event_type         ev;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              ovf;
      logic              last;
   } deframe_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the flag registers, the frame store,
   // the fill count, the pending escape and the overflow flag. Each accepted
   // byte may queue results; each result item is checked against the oldest.
   // ------------------------------------------------------------------------
   class deframe_scoreboard_type;
      logic [DATA_W-1:0]  lead_flag, trail_flag, ack_flag, esc_flag;
      logic [DATA_W-1:0]  stored [STORE_DEPTH];
      int unsigned        fill;
      bit                 esc_pending;
      bit                 dropped;
      deframe_result_type due [$];
      int unsigned        faults;
      int unsigned        n_data, n_empty, n_ack, n_ovf;

      function new();
         lead_flag   = LEAD_RST;
         trail_flag  = TRAIL_RST;
         ack_flag    = ACK_RST;
         esc_flag    = ESC_RST;
         fill        = 0;
         esc_pending = 1'b0;
         dropped     = 1'b0;
         faults      = 0;
         n_data = 0; n_empty = 0; n_ack = 0; n_ovf = 0;
      endfunction

      function void set_flags(logic [DATA_W-1:0] lead, logic [DATA_W-1:0] trail,
                              logic [DATA_W-1:0] ack, logic [DATA_W-1:0] esc);
         lead_flag  = lead;
         trail_flag = trail;
         ack_flag   = ack;
         esc_flag   = esc;
      endfunction

      function void keep_byte(logic [DATA_W-1:0] b);
         if (fill < STORE_DEPTH) begin
            stored[fill] = b;
            fill++;
         end else begin
            dropped = 1'b1;
         end
      endfunction

      function void queue_result(event_type ev, logic [DATA_W-1:0] data,
                                 logic [LEN_W-1:0] len, logic ovf, logic last);
         deframe_result_type r;
         r.ev   = ev;
         r.data = data;
         r.len  = len;
         r.ovf  = ovf;
         r.last = last;
         due.push_back(r);
      endfunction

      // one accepted received byte
      function void note_rx(logic [DATA_W-1:0] b);
         if (esc_pending) begin
            keep_byte(b);
            esc_pending = 1'b0;
         end else if (b == lead_flag) begin
            fill    = 0;
            dropped = 1'b0;
         end else if (b == trail_flag) begin
            if (fill == 0)
               queue_result(EV_EMPTY, '0, '0, dropped, 1'b1);
            else
               for (int k = 0; k < fill; k++)
                  queue_result(EV_DATA, stored[k], LEN_W'(fill), dropped, k + 1 == fill);
         end else if (b == ack_flag) begin
            queue_result(EV_ACK, '0, '0, 1'b0, 1'b1);
         end else if (b == esc_flag) begin
            esc_pending = 1'b1;
         end else begin
            keep_byte(b);
         end
      endfunction

      // one accepted result item
      function void check(deframe_result_type got);
         deframe_result_type want;
         case (got.ev)
            EV_DATA:  n_data++;
            EV_EMPTY: n_empty++;
            EV_ACK:   n_ack++;
            default:  ;
         endcase
         if (got.ovf === 1'b1) n_ovf++;
         if (due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: result with none due: ev %0d data %02h len %0d ovf %0b last %0b",
                        $realtime, got.ev, got.data, got.len, got.ovf, got.last);
            return;
         end
         want = due.pop_front();
         if (got.ev !== want.ev || got.data !== want.data || got.len !== want.len ||
             got.ovf !== want.ovf || got.last !== want.last) begin
            faults++;
            if (faults <= 10) begin
               $display("%0t: mismatch: expected ev %0d data %02h len %0d ovf %0b last %0b",
                        $realtime, want.ev, want.data, want.len, want.ovf, want.last);
               $display("%0t:           got      ev %0d data %02h len %0d ovf %0b last %0b",
                        $realtime, got.ev, got.data, got.len, got.ovf, got.last);
            end
         end
      endfunction

      function int unsigned outstanding();
         return due.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, channels, block
   // ------------------------------------------------------------------------
   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   dsfr_req_if req_ch ();
   dsfr_rsp_if rsp_ch ();

   dle_stuffed_frame_receiver_top #(
      .FRAME_DEPTH (STORE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #10_000_000;
      $display("[dle_stuffed_frame_receiver_top] ERROR");
      $finish;
   end

   deframe_scoreboard_type sb = new();

   // flag values currently loaded, used to shape the traffic
   logic [DATA_W-1:0] flag_lead  = LEAD_RST;
   logic [DATA_W-1:0] flag_trail = TRAIL_RST;
   logic [DATA_W-1:0] flag_ack   = ACK_RST;
   logic [DATA_W-1:0] flag_esc   = ESC_RST;

   int unsigned items_sent   = 0;
   bit          sender_quiet = 1'b0;  // stretches with no gaps on the input
   bit          rsp_quiet    = 1'b0;  // stretches with no stalls on the output
   bit          rsp_hold_req = 1'b0;  // asks the output side for one long hold

   function automatic int unsigned draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   function automatic bit is_flag(logic [DATA_W-1:0] b);
      return b == flag_lead || b == flag_trail || b == flag_ack || b == flag_esc;
   endfunction

   function automatic logic [DATA_W-1:0] pick_flag();
      case ($urandom_range(0, 3))
         0:       return flag_lead;
         1:       return flag_trail;
         2:       return flag_ack;
         default: return flag_esc;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Input side. valid is left high after an accepted item; the next call
   // either replaces the byte at once or lowers valid for its gap.
   // ------------------------------------------------------------------------
   task automatic send_byte(logic [DATA_W-1:0] b);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) sender_quiet = !sender_quiet;
      gap = draw_wait(sender_quiet);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_rx(b);
      items_sent++;
   endtask

   // drop valid, wait for every due result, then let the engine go quiet
   task automatic settle(int unsigned tail);
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // all four flag registers, back to back; block must be idle
   task automatic load_flags(logic [DATA_W-1:0] lead, logic [DATA_W-1:0] trail,
                             logic [DATA_W-1:0] ack, logic [DATA_W-1:0] esc);
      csr_we    <= 1'b1;
      csr_index <= CSR_LEAD;
      csr_wdata <= lead;
      @(posedge clock);
      csr_index <= CSR_TRAIL;
      csr_wdata <= trail;
      @(posedge clock);
      csr_index <= CSR_ACK;
      csr_wdata <= ack;
      @(posedge clock);
      csr_index <= CSR_ESC;
      csr_wdata <= esc;
      @(posedge clock);
      csr_we <= 1'b0;
      flag_lead  = lead;
      flag_trail = trail;
      flag_ack   = ack;
      flag_esc   = esc;
      sb.set_flags(lead, trail, ack, esc);
   endtask

   // Mostly well-formed: leading flag, payload with flag values escaped,
   // trailing flag. Now and then a missing flag, an unescaped flag value,
   // a repeated trailing flag, an ack mid-frame or a frame past the store.
   task automatic send_frame(int unsigned len_max);
      int unsigned       n;
      logic [DATA_W-1:0] b;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 67) : $urandom_range(0, len_max);
      if ($urandom_range(0, 9) != 0) send_byte(flag_lead);
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(0, 3) == 0) ? pick_flag() : DATA_W'($urandom_range(0, 255));
         if (is_flag(b) && $urandom_range(0, 9) != 0) send_byte(flag_esc);
         send_byte(b);
         if ($urandom_range(0, 24) == 0) send_byte(flag_ack);
      end
      if ($urandom_range(0, 11) != 0) send_byte(flag_trail);
      if ($urandom_range(0, 4) == 0) send_byte(flag_trail);
   endtask

   task automatic random_phase(int unsigned budget);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) send_byte(DATA_W'($urandom_range(0, 255)));
         else
            send_frame(12);
      end
   endtask

   // Output held off while a frame past the store depth goes in, then two
   // trailing flags, an ack and more bytes: the command queue fills and the
   // stored bytes wait on the delivery, so the input stalls.
   task automatic squeeze_output();
      logic [DATA_W-1:0] b;
      rsp_hold_req = 1'b1;
      send_byte(flag_lead);
      repeat (FILL_BYTES) begin
         b = DATA_W'($urandom_range(0, 255));
         if (is_flag(b)) send_byte(flag_esc);
         send_byte(b);
      end
      send_byte(flag_trail);
      send_byte(flag_trail);
      send_byte(flag_ack);
      send_byte(8'h41);
      send_byte(8'h42);
      send_byte(flag_trail);
   endtask

   // ------------------------------------------------------------------------
   // Output side: random stall per item, checks every accepted result.
   // The long hold-off is counted here, independent of the input side.
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned        stall;
      deframe_result_type got;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
         stall = draw_wait(rsp_quiet);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid && !rsp_hold_req);
         if (rsp_ch.valid) begin
            got.ev   = event_type'(rsp_ch.event_res);
            got.data = rsp_ch.data_byte;
            got.len  = rsp_ch.frame_length;
            got.ovf  = rsp_ch.overflow;
            got.last = rsp_ch.last;
            sb.check(got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed opening at the reset flag values (lead 2, trail 3, ack 6,
   // esc 16):
   //   trailing flag straight after reset   -> empty frame
   //   ack                                   -> ack event
   //   frame with 00, FF and every flag value escaped, incl. the escape
   //   itself, then the trailing flag twice   -> same frame delivered twice
   //   leading then trailing flag            -> empty frame
   //   escaped ordinary byte                 -> one-byte frame
   //   ack inside a fresh frame, then trail  -> ack, then empty frame
   // ------------------------------------------------------------------------
   localparam logic [DATA_W-1:0] OPENING [24] = '{
      TRAIL_RST, ACK_RST,
      LEAD_RST, 8'h00, 8'hFF, ESC_RST, LEAD_RST, ESC_RST, TRAIL_RST,
      ESC_RST, ACK_RST, ESC_RST, ESC_RST, 8'hA5, TRAIL_RST, TRAIL_RST,
      LEAD_RST, TRAIL_RST,
      ESC_RST, 8'h80, TRAIL_RST,
      LEAD_RST, ACK_RST, TRAIL_RST
   };

   initial begin : stimulus
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_LEAD;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING[i]) send_byte(OPENING[i]);

      // extremes of the flag registers, both ways round
      settle(20);
      load_flags(8'h00, 8'hFF, 8'h01, 8'hFE);
      random_phase(15);
      settle(20);
      load_flags(8'hFF, 8'h00, 8'hFE, 8'h01);
      random_phase(15);

      // equal values: trailing beats ack, leading beats escape
      settle(20);
      load_flags(8'h10, 8'h20, 8'h20, 8'h10);
      random_phase(15);

      // arbitrary values, collisions allowed
      settle(20);
      load_flags(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                 DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
      random_phase(15);

      // back to the defaults for the overflow and back-pressure case
      settle(20);
      load_flags(LEAD_RST, TRAIL_RST, ACK_RST, ESC_RST);
      squeeze_output();

      // allow for a full frame walk and for strays after it
      settle(150);

      $display("ran %0d input items over five flag settings; %0d results checked:",
               items_sent, sb.n_data + sb.n_empty + sb.n_ack);
      $display("  %0d frame bytes, %0d empty frames, %0d acks, %0d with overflow set",
               sb.n_data, sb.n_empty, sb.n_ack, sb.n_ovf);
      if (sb.faults == 0 && sb.outstanding() == 0) begin
         $display("[dle_stuffed_frame_receiver_top] OK");
      end else begin
         $display("%0d failing results", sb.faults);
         $display("[dle_stuffed_frame_receiver_top] ERROR");
      end
      $finish;
   end

endmodule
